### hw/rtl/utf8d_pkg.sv
package utf8d_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CpWidth   = 21;
   localparam int unsigned QueueDepth = 3;

   localparam logic [CpWidth-1:0] REPLACEMENT_CP = 21'h00FFFD;
   localparam logic [CpWidth-1:0] CP_LIMIT       = 21'h110000;

   // One result item as it waits in the output queue.
   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               last_of_run;
   } rsp_item_type;

   // What one accepted byte produces: zero, one or two results, in order.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } dec_out_type;

endpackage

### hw/rtl/utf8d_core.sv
module utf8d_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 byte_accept,
   input  logic [utf8d_pkg::ByteWidth-1:0]      byte_data,
   output utf8d_pkg::dec_out_type               dec_out
);

   logic                                seq_pending_ff, seq_pending_in;
   logic [1:0]                          conts_left_ff, conts_left_in;
   logic [utf8d_pkg::CpWidth-1:0]       accum_value_ff, accum_value_in;

   logic                                is_cont;
   logic                                flush_bad;
   logic [utf8d_pkg::CpWidth-1:0]       flush_cp;
   logic                                byte_has_result;
   logic [utf8d_pkg::CpWidth-1:0]       byte_cp;

   assign is_cont   = (byte_data[7:6] == 2'b10);
   assign flush_bad = (conts_left_ff != 2'd0) || (accum_value_ff >= utf8d_pkg::CP_LIMIT);
   assign flush_cp  = flush_bad ? utf8d_pkg::REPLACEMENT_CP : accum_value_ff;

   always_comb begin
      byte_has_result = 1'b0;
      byte_cp         = utf8d_pkg::REPLACEMENT_CP;
      if (byte_data[7] == 1'b0) begin
         byte_has_result = 1'b1;
         byte_cp         = {{(utf8d_pkg::CpWidth-utf8d_pkg::ByteWidth){1'b0}}, byte_data};
      end else if (byte_data[7:3] == 5'b11111) begin
         byte_has_result = 1'b1;
      end
   end

   always_comb begin
      seq_pending_in = seq_pending_ff;
      conts_left_in  = conts_left_ff;
      accum_value_in = accum_value_ff;
      dec_out        = '0;
      dec_out.first.code_point  = utf8d_pkg::REPLACEMENT_CP;
      dec_out.second.code_point = utf8d_pkg::REPLACEMENT_CP;
      dec_out.second.last_of_run = 1'b1;
      if (is_cont) begin
         if (seq_pending_ff && (conts_left_ff != 2'd0)) begin
            accum_value_in = {accum_value_ff[utf8d_pkg::CpWidth-7:0], byte_data[5:0]};
            conts_left_in  = conts_left_ff - 2'd1;
         end else begin
            // A run that is already complete gets a replacement of its own
            // ahead of the one for the stray byte.
            dec_out.count = seq_pending_ff ? 2'd2 : 2'd1;
            dec_out.first.last_of_run = !seq_pending_ff;
            seq_pending_in = 1'b0;
            conts_left_in  = 2'd0;
            accum_value_in = '0;
         end
      end else begin
         dec_out.count = {1'b0, seq_pending_ff} + {1'b0, byte_has_result};
         if (seq_pending_ff) begin
            dec_out.first.code_point  = flush_cp;
            dec_out.first.last_of_run = !byte_has_result;
            dec_out.second.code_point = byte_cp;
         end else begin
            dec_out.first.code_point  = byte_cp;
            dec_out.first.last_of_run = 1'b1;
         end
         seq_pending_in = 1'b0;
         conts_left_in  = 2'd0;
         accum_value_in = '0;
         if (!byte_has_result) begin
            seq_pending_in = 1'b1;
            priority if (byte_data[7:4] == 4'b1111) begin
               conts_left_in  = 2'd3;
               accum_value_in = {{(utf8d_pkg::CpWidth-3){1'b0}}, byte_data[2:0]};
            end else if (byte_data[7:5] == 3'b111) begin
               conts_left_in  = 2'd2;
               accum_value_in = {{(utf8d_pkg::CpWidth-4){1'b0}}, byte_data[3:0]};
            end else begin
               conts_left_in  = 2'd1;
               accum_value_in = {{(utf8d_pkg::CpWidth-5){1'b0}}, byte_data[4:0]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_pending_ff <= 1'b0;
         conts_left_ff  <= 2'd0;
         accum_value_ff <= '0;
      end else if (byte_accept) begin
         seq_pending_ff <= seq_pending_in;
         conts_left_ff  <= conts_left_in;
         accum_value_ff <= accum_value_in;
      end
   end

endmodule

### hw/rtl/utf8d_outq.sv
module utf8d_outq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  utf8d_pkg::dec_out_type      push_data,
   input  logic                        pop,
   output logic                        head_valid,
   output utf8d_pkg::rsp_item_type     head_item,
   output logic                        has_room
);

   utf8d_pkg::rsp_item_type entry_ff [utf8d_pkg::QueueDepth];
   utf8d_pkg::rsp_item_type entry_in [utf8d_pkg::QueueDepth];
   logic [1:0]              count_ff, count_in;
   logic [1:0]              base;
   logic [1:0]              push_count;

   assign head_valid = (count_ff != 2'd0);
   assign head_item  = entry_ff[0];
   // Room for the worst case of two results, whether or not the head leaves.
   assign has_room   = (count_ff <= 2'd1);

   assign push_count = push ? push_data.count : 2'd0;
   assign base       = count_ff - {1'b0, pop};
   assign count_in   = base + push_count;

   always_comb begin
      for (int i = 0; i < utf8d_pkg::QueueDepth; i++) begin
         if (pop && (i < utf8d_pkg::QueueDepth - 1)) begin
            entry_in[i] = entry_ff[i+1];
         end else begin
            entry_in[i] = entry_ff[i];
         end
         if ((push_count != 2'd0) && (base == 2'(i))) begin
            entry_in[i] = push_data.first;
         end
         if ((push_count == 2'd2) && ((base + 2'd1) == 2'(i))) begin
            entry_in[i] = push_data.second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < utf8d_pkg::QueueDepth; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

endmodule

### hw/rtl/utf8_stream_decoder.sv
// Channel    Direction  Signals                          Contents
// req        in         req_tvalid/tready/tdata[7:0]     in_byte
// rsp        out        rsp_tvalid/tready/tdata[23:0]    code_point, zero fill
//                       rsp_tlast                        last_of_run
//
// A byte is decoded in the cycle of its transfer; its results sit in a
// three-entry output queue and can leave on the next cycle.
// One byte per cycle is taken while at most one result waits; a byte that
// yields two results then stalls req until at most one result waits.
// Reset clears the open sequence and empties the queue.
// A stall on rsp holds req_tready low once two results are waiting.
module utf8_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] code_point, [23:21] zero
   output logic        rsp_tlast    // last_of_run
);

   logic                    byte_accept;
   logic                    has_room;
   utf8d_pkg::dec_out_type  dec_out;
   utf8d_pkg::rsp_item_type head_item;

   assign req_tready  = has_room;
   assign byte_accept = req_tvalid && has_room;

   utf8d_core u_core (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .byte_data   (req_tdata),
      .dec_out     (dec_out)
   );

   utf8d_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (byte_accept),
      .push_data  (dec_out),
      .pop        (rsp_tvalid && rsp_tready),
      .head_valid (rsp_tvalid),
      .head_item  (head_item),
      .has_room   (has_room)
   );

   assign rsp_tdata = {3'b000, head_item.code_point};
   assign rsp_tlast = head_item.last_of_run;

endmodule

### test/utf8_stream_checker.sv
module utf8_stream_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [20:0] code_point, [23:21] zero
   input  logic        rsp_tlast,   // last_of_run
   output int          error_count,
   output int          outstanding,
   output int          points_checked,
   output int          replacements_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RspWidth = 24;

   utf8d_pkg::rsp_item_type decoded_points [$];

   // Own copy of the decoder state.
   logic                          seq_open     = 1'b0;
   logic [1:0]                    conts_needed = 2'd0;
   logic [utf8d_pkg::CpWidth-1:0] accum        = '0;

   int errors   = 0;
   int checked  = 0;
   int replaced = 0;

   // Works out the code points that one accepted byte produces and queues them.
   task automatic decode_byte(input logic [7:0] b);
      logic [utf8d_pkg::CpWidth-1:0] cps [2];
      utf8d_pkg::rsp_item_type       item;
      int                            n;
      n = 0;
      if (b[7:6] == 2'b10) begin
         if (seq_open && conts_needed != 2'd0) begin
            accum        = {accum[utf8d_pkg::CpWidth-7:0], b[5:0]};
            conts_needed = conts_needed - 2'd1;
         end else begin
            // A continuation past the end of a complete run rejects both.
            if (seq_open) begin
               cps[n] = utf8d_pkg::REPLACEMENT_CP;
               n++;
            end
            cps[n] = utf8d_pkg::REPLACEMENT_CP;
            n++;
            seq_open     = 1'b0;
            conts_needed = 2'd0;
            accum        = '0;
         end
      end else begin
         // Any other byte closes the open sequence first.
         if (seq_open) begin
            cps[n] = (conts_needed != 2'd0 || accum >= utf8d_pkg::CP_LIMIT)
                     ? utf8d_pkg::REPLACEMENT_CP : accum;
            n++;
            seq_open     = 1'b0;
            conts_needed = 2'd0;
            accum        = '0;
         end
         if (!b[7]) begin
            cps[n] = {{(utf8d_pkg::CpWidth-8){1'b0}}, b};
            n++;
         end else if (b[7:3] == 5'b11111) begin
            cps[n] = utf8d_pkg::REPLACEMENT_CP;
            n++;
         end else if (b[7:4] == 4'b1111) begin
            seq_open     = 1'b1;
            conts_needed = 2'd3;
            accum        = {{(utf8d_pkg::CpWidth-3){1'b0}}, b[2:0]};
         end else if (b[7:5] == 3'b111) begin
            seq_open     = 1'b1;
            conts_needed = 2'd2;
            accum        = {{(utf8d_pkg::CpWidth-4){1'b0}}, b[3:0]};
         end else begin
            seq_open     = 1'b1;
            conts_needed = 2'd1;
            accum        = {{(utf8d_pkg::CpWidth-5){1'b0}}, b[4:0]};
         end
      end
      for (int i = 0; i < n; i++) begin
         item.code_point  = cps[i];
         item.last_of_run = (i == n - 1);
         decoded_points.push_back(item);
      end
   endtask

   always @(posedge clock) begin : watch
      utf8d_pkg::rsp_item_type want;
      if (reset) begin
         seq_open     = 1'b0;
         conts_needed = 2'd0;
         accum        = '0;
         decoded_points.delete();
      end else begin
         // A result transfer always belongs to a byte taken at an earlier edge.
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (decoded_points.size() == 0) begin
               errors++;
               $error("rsp: result with none expected, code_point %0h",
                      rsp_tdata[utf8d_pkg::CpWidth-1:0]);
            end else begin
               want = decoded_points.pop_front();
               if (want.code_point == utf8d_pkg::REPLACEMENT_CP) replaced++;
               if (rsp_tdata[utf8d_pkg::CpWidth-1:0] !== want.code_point) begin
                  errors++;
                  $error("code_point: expected %0h, actual %0h",
                         want.code_point, rsp_tdata[utf8d_pkg::CpWidth-1:0]);
               end
               if (rsp_tlast !== want.last_of_run) begin
                  errors++;
                  $error("last_of_run: expected %0b, actual %0b",
                         want.last_of_run, rsp_tlast);
               end
               if (rsp_tdata[RspWidth-1:utf8d_pkg::CpWidth] !== '0) begin
                  errors++;
                  $error("tdata fill: expected 0, actual %0h",
                         rsp_tdata[RspWidth-1:utf8d_pkg::CpWidth]);
               end
            end
         end
         if (req_tvalid && req_tready) decode_byte(req_tdata);
      end
      error_count          <= errors;
      outstanding          <= decoded_points.size();
      points_checked       <= checked;
      replacements_checked <= replaced;
   end

endmodule

### test/tb_utf8_stream_decoder.sv
module tb_utf8_stream_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomItems = 1500;
   localparam int HoldCycles  = 80;
   localparam int DrainCycles = 20;
   localparam int TimeoutNs   = 1_000_000;

   typedef enum {
      SinkOpen,
      SinkCoin,
      SinkSlow,
      SinkPulse
   } sink_mode_type;

   typedef enum {
      PieceAscii,
      PieceTwo,
      PieceThree,
      PieceFour,
      PieceHigh,
      PieceShort,
      PieceExtra,
      PieceStray,
      PieceBadLead,
      PieceEnd,
      PieceNoise
   } piece_kind_type;

   logic                            clock;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic [utf8d_pkg::ByteWidth-1:0] req_tdata  = '0;
   logic                            rsp_tready = 1'b0;
   wire                             req_tready;
   wire                             rsp_tvalid;
   wire  [23:0]                     rsp_tdata;
   wire                             rsp_tlast;

   int error_count;
   int outstanding;
   int points_checked;
   int replacements_checked;

   int bytes_sent     = 0;
   int burst_left     = 0;
   int hold_off_asks  = 0;
   int hold_offs_done = 0;

   logic [7:0] directed_text [25];

   utf8_stream_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   utf8_stream_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_tvalid           (req_tvalid),
      .req_tready           (req_tready),
      .req_tdata            (req_tdata),
      .rsp_tvalid           (rsp_tvalid),
      .rsp_tready           (rsp_tready),
      .rsp_tdata            (rsp_tdata),
      .rsp_tlast            (rsp_tlast),
      .error_count          (error_count),
      .outstanding          (outstanding),
      .points_checked       (points_checked),
      .replacements_checked (replacements_checked)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Offers one byte and returns at the edge of its transfer.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // Sends one piece of text: mostly well-formed characters, some malformed runs.
   task automatic send_text_piece();
      logic [7:0]     seq [$];
      logic [20:0]    cp;
      logic [31:0]    raw;
      int             pick;
      int             len;
      piece_kind_type kind;
      pick = $urandom_range(0, 99);
      kind = pick < 25 ? PieceAscii   :
             pick < 45 ? PieceTwo     :
             pick < 62 ? PieceThree   :
             pick < 78 ? PieceFour    :
             pick < 81 ? PieceHigh    :
             pick < 85 ? PieceShort   :
             pick < 89 ? PieceExtra   :
             pick < 92 ? PieceStray   :
             pick < 95 ? PieceBadLead :
             pick < 97 ? PieceEnd     : PieceNoise;
      case (kind)
         PieceAscii: begin
            seq.push_back(8'($urandom_range(1, 127)));
         end
         PieceTwo: begin
            cp = 21'($urandom_range(0, 'h7FF));
            seq.push_back({3'b110, cp[10:6]});
            seq.push_back({2'b10, cp[5:0]});
         end
         PieceThree: begin
            cp = 21'($urandom_range(0, 'hFFFF));
            seq.push_back({4'b1110, cp[15:12]});
            seq.push_back({2'b10, cp[11:6]});
            seq.push_back({2'b10, cp[5:0]});
         end
         PieceFour, PieceHigh: begin
            cp = (kind == PieceFour) ? 21'($urandom_range(0, 'h10FFFF))
                                     : 21'($urandom_range('h110000, 'h1FFFFF));
            seq.push_back({5'b11110, cp[20:18]});
            seq.push_back({2'b10, cp[17:12]});
            seq.push_back({2'b10, cp[11:6]});
            seq.push_back({2'b10, cp[5:0]});
         end
         PieceShort, PieceExtra: begin
            len = $urandom_range(2, 4);
            raw = $urandom;
            case (len)
               2: seq.push_back({3'b110, raw[4:0]});
               3: seq.push_back({4'b1110, raw[3:0]});
               default: seq.push_back({5'b11110, raw[2:0]});
            endcase
            for (int i = 1; i < len; i++) begin
               raw = $urandom;
               seq.push_back({2'b10, raw[5:0]});
            end
            if (kind == PieceShort) begin
               repeat ($urandom_range(1, len - 1)) void'(seq.pop_back());
            end else begin
               repeat ($urandom_range(1, 2)) begin
                  raw = $urandom;
                  seq.push_back({2'b10, raw[5:0]});
               end
            end
         end
         PieceStray: begin
            repeat ($urandom_range(1, 2)) seq.push_back(8'($urandom_range('h80, 'hBF)));
         end
         PieceBadLead: begin
            seq.push_back(8'($urandom_range('hF8, 'hFF)));
         end
         PieceEnd: begin
            seq.push_back(8'h00);
         end
         default: begin
            repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom));
         end
      endcase
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   // Receiver: stall patterns in segments, plus long hold-offs on request.
   initial begin : sink
      sink_mode_type mode;
      int            run_len;
      @(posedge clock);
      forever begin
         if (hold_off_asks > hold_offs_done) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_offs_done++;
         end else begin
            mode    = sink_mode_type'($urandom_range(0, 3));
            run_len = $urandom_range(1, 60);
            for (int k = 0; k < run_len; k++) begin
               case (mode)
                  SinkOpen:  rsp_tready <= 1'b1;
                  SinkCoin:  rsp_tready <= 1'($urandom_range(0, 1));
                  SinkSlow:  rsp_tready <= ($urandom_range(0, 3) == 0);
                  default:   rsp_tready <= (k % 3 != 1);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      int pieces;
      // ASCII extremes, each multi-byte length, a lead of F8 and above, a stray
      // continuation, a short sequence, an extra continuation, a value above
      // the code space, and a zero byte that flushes an open sequence.
      directed_text = '{8'h00, 8'h7F,
                        8'hC3, 8'hA9,
                        8'hE2, 8'h82, 8'hAC,
                        8'hF0, 8'h9F, 8'h98, 8'h80,
                        8'hF8, 8'hFF, 8'h80,
                        8'hC2, 8'h41,
                        8'hDF, 8'hBF, 8'hBF,
                        8'hF7, 8'hBF, 8'hBF, 8'hBF,
                        8'hE0, 8'h00};
      pieces = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_text[i]) send_byte(directed_text[i]);
      while (bytes_sent < RandomItems + 25) begin
         // The sender keeps offering while the receiver holds off, so the
         // output queue fills and the input side has to stall.
         if (pieces % 400 == 0) hold_off_asks <= hold_off_asks + 1;
         send_text_piece();
         pieces++;
      end
      // A final zero flushes any sequence left open.
      send_byte(8'h00);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("Sent %0d bytes in %0d random pieces; checked %0d code points, %0d replacements,",
               bytes_sent, pieces, points_checked, replacements_checked);
      $display("with %0d long output hold-offs and random stalls on both channels.",
               hold_offs_done);
      if (error_count == 0 && outstanding == 0) begin
         $display("** utf8_stream_decoder: PASSED **");
      end else begin
         $display("** utf8_stream_decoder: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #(TimeoutNs);
      $display("** utf8_stream_decoder: FAILED **");
      $finish;
   end

endmodule

### files.f
hw/rtl/utf8d_pkg.sv
hw/rtl/utf8d_core.sv
hw/rtl/utf8d_outq.sv
hw/rtl/utf8_stream_decoder.sv
test/utf8_stream_checker.sv
test/tb_utf8_stream_decoder.sv
